// File: src/cbz_pkg.sv
// Shared types and constants for the cubic Bezier point/tangent evaluator.
`default_nettype none
package cbz_pkg;
   localparam int CoordW = 16;
   localparam int ParamW = 17;
   localparam int SlopeW = 19;
   localparam int HeadW = 16;
   localparam int AngW = 32;
   localparam int TableLen = 24;
   localparam int CordW = 24;
   localparam int RegIdxW = 3;

   typedef enum logic [RegIdxW-1:0] {
      REG_START_X = 3'd0,
      REG_START_Y = 3'd1,
      REG_CTRL_A_X = 3'd2,
      REG_CTRL_A_Y = 3'd3,
      REG_CTRL_B_X = 3'd4,
      REG_CTRL_B_Y = 3'd5,
      REG_END_X = 3'd6,
      REG_END_Y = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [CordW-1:0] x;
      logic signed [CordW-1:0] y;
      logic signed [AngW-1:0] z;
      logic zero;
   } cordic_type;

   function automatic logic signed [AngW-1:0] atan_entry(input int i);
      logic signed [AngW-1:0] v;
      case (i)
         0: v = 32'sd1474560;
         1: v = 32'sd870484;
         2: v = 32'sd459940;
         3: v = 32'sd233473;
         4: v = 32'sd117189;
         5: v = 32'sd58652;
         6: v = 32'sd29333;
         7: v = 32'sd14667;
         8: v = 32'sd7334;
         9: v = 32'sd3667;
         10: v = 32'sd1833;
         11: v = 32'sd917;
         12: v = 32'sd458;
         13: v = 32'sd229;
         14: v = 32'sd115;
         15: v = 32'sd57;
         16: v = 32'sd29;
         17: v = 32'sd14;
         18: v = 32'sd7;
         19: v = 32'sd4;
         20: v = 32'sd2;
         21: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// File: src/cubic_bezier_point_tangent.sv
// Top level: cubic Bezier point, derivative and tangent heading pipeline.
//  channel | ports                          | handshake
//  request | req_curve_param                | start & !busy
//  result  | rsp_point_*, rsp_slope_*, head | rsp_valid, one cycle, no stall
//  config  | csr_write, csr_index, csr_data | csr_write
// One word enters per cycle; busy is always low. The path holds 7 + CORDIC_STEPS
// register stages, CORDIC_STEPS capped at 24 (five curve stages, a CORDIC prestage,
// one stage per micro-rotation, an output stage). Reset clears the valid bits
// and the control point registers.
`default_nettype none
module cubic_bezier_point_tangent #(
   parameter int CORDIC_STEPS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [cbz_pkg::ParamW-1:0] req_curve_param,
   input wire logic csr_write,
   input wire logic [cbz_pkg::RegIdxW-1:0] csr_index,
   input wire logic [cbz_pkg::CoordW-1:0] csr_data,
   output logic rsp_valid,
   output logic signed [cbz_pkg::CoordW-1:0] rsp_point_x,
   output logic signed [cbz_pkg::CoordW-1:0] rsp_point_y,
   output logic signed [cbz_pkg::SlopeW-1:0] rsp_slope_x,
   output logic signed [cbz_pkg::SlopeW-1:0] rsp_slope_y,
   output logic signed [cbz_pkg::HeadW-1:0] rsp_heading
);
   localparam int CW = cbz_pkg::CoordW;
   localparam int SW = cbz_pkg::SlopeW;
   localparam int Lat = 2 + ((CORDIC_STEPS > cbz_pkg::TableLen) ? cbz_pkg::TableLen
                                                               : CORDIC_STEPS);

   logic signed [CW-1:0] regs_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
      end else if (csr_write) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   assign busy = 1'b0;

   // stage 1: clamp t, u
   logic [16:0] t1_ff, u1_ff;
   logic v1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      t1_ff <= (req_curve_param > 17'd65536) ? 17'd65536 : req_curve_param;
      u1_ff <= 17'd65536 - ((req_curve_param > 17'd65536) ? 17'd65536 : req_curve_param);
   end

   // stage 2: quadratic weights (Q0.32, up to 2^32)
   logic [33:0] uu2_ff, ut2_ff, tt2_ff;
   logic [16:0] t2_ff, u2_ff;
   logic v2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      uu2_ff <= 34'(u1_ff * u1_ff);
      ut2_ff <= 34'(u1_ff * t1_ff);
      tt2_ff <= 34'(t1_ff * t1_ff);
      t2_ff <= t1_ff;
      u2_ff <= u1_ff;
   end

   // stage 3: cubic weights (Q0.48); quadratic weights passed along
   logic [50:0] b0_ff, b1_ff, b2_ff, b3_ff;
   logic [33:0] uu3_ff, ut3_ff, tt3_ff;
   logic v3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      b0_ff <= 51'(uu2_ff * u2_ff);
      b1_ff <= 51'(uu2_ff * t2_ff) * 51'd3;
      b2_ff <= 51'(tt2_ff * u2_ff) * 51'd3;
      b3_ff <= 51'(tt2_ff * t2_ff);
      uu3_ff <= uu2_ff;
      ut3_ff <= ut2_ff;
      tt3_ff <= tt2_ff;
   end

   // stage 4: weighted products
   logic signed [68:0] px_ff [4], py_ff [4];
   logic signed [53:0] sx_ff [3], sy_ff [3];
   logic v4_ff;
   always_ff @(posedge clock) begin
      logic signed [51:0] bw [4];
      logic signed [35:0] qw [3];
      bw[0] = $signed({1'b0, b0_ff});
      bw[1] = $signed({1'b0, b1_ff});
      bw[2] = $signed({1'b0, b2_ff});
      bw[3] = $signed({1'b0, b3_ff});
      qw[0] = $signed({2'b0, uu3_ff});
      qw[1] = $signed({1'b0, ut3_ff, 1'b0});
      qw[2] = $signed({2'b0, tt3_ff});
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      for (int k = 0; k < 4; k++) begin
         px_ff[k] <= 69'(bw[k] * regs_ff[2*k]);
         py_ff[k] <= 69'(bw[k] * regs_ff[2*k+1]);
      end
      for (int k = 0; k < 3; k++) begin
         sx_ff[k] <= 54'(qw[k] * (17'(regs_ff[2*k+2]) - 17'(regs_ff[2*k])));
         sy_ff[k] <= 54'(qw[k] * (17'(regs_ff[2*k+3]) - 17'(regs_ff[2*k+1])));
      end
   end

   // stage 5: sum and round, saturate the point
   logic signed [68:0] psx, psy;
   logic signed [55:0] ssx, ssy;
   logic signed [CW-1:0] px5_in, py5_in, px5_ff, py5_ff;
   logic signed [SW-1:0] sx5_in, sy5_in;
   logic v5_ff;
   always_comb begin
      psx = ((px_ff[0] + px_ff[1] + px_ff[2] + px_ff[3]) + (69'sd1 <<< 47)) >>> 48;
      psy = ((py_ff[0] + py_ff[1] + py_ff[2] + py_ff[3]) + (69'sd1 <<< 47)) >>> 48;
      ssx = ((56'(sx_ff[0]) + 56'(sx_ff[1]) + 56'(sx_ff[2])) * 56'sd3
             + (56'sd1 <<< 31)) >>> 32;
      ssy = ((56'(sy_ff[0]) + 56'(sy_ff[1]) + 56'(sy_ff[2])) * 56'sd3
             + (56'sd1 <<< 31)) >>> 32;
      px5_in = (psx > 69'sd32767) ? 16'sh7fff : (psx < -69'sd32768) ? 16'sh8000 : CW'(psx);
      py5_in = (psy > 69'sd32767) ? 16'sh7fff : (psy < -69'sd32768) ? 16'sh8000 : CW'(psy);
      sx5_in = SW'(ssx);
      sy5_in = SW'(ssy);
   end

   logic signed [SW-1:0] sx5_ff, sy5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      px5_ff <= px5_in;
      py5_ff <= py5_in;
      sx5_ff <= sx5_in;
      sy5_ff <= sy5_in;
   end

   // delay line for point and slope alongside the CORDIC
   logic signed [CW-1:0] pxd_ff [Lat], pyd_ff [Lat];
   logic signed [SW-1:0] sxd_ff [Lat], syd_ff [Lat];
   always_ff @(posedge clock) begin
      pxd_ff[0] <= px5_ff;
      pyd_ff[0] <= py5_ff;
      sxd_ff[0] <= sx5_ff;
      syd_ff[0] <= sy5_ff;
      for (int k = 1; k < Lat; k++) begin
         pxd_ff[k] <= pxd_ff[k-1];
         pyd_ff[k] <= pyd_ff[k-1];
         sxd_ff[k] <= sxd_ff[k-1];
         syd_ff[k] <= syd_ff[k-1];
      end
   end

   cbz_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock),
      .reset(reset),
      .in_valid(v5_ff),
      .in_x(sx5_ff),
      .in_y(sy5_ff),
      .out_valid(rsp_valid),
      .out_heading(rsp_heading)
   );

   assign rsp_point_x = pxd_ff[Lat-1];
   assign rsp_point_y = pyd_ff[Lat-1];
   assign rsp_slope_x = sxd_ff[Lat-1];
   assign rsp_slope_y = syd_ff[Lat-1];
endmodule
`default_nettype wire

// File: src/cbz_cordic.sv
// Pipelined CORDIC vectoring unit producing the tangent heading.
`default_nettype none
module cbz_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   input wire logic signed [cbz_pkg::SlopeW-1:0] in_x,
   input wire logic signed [cbz_pkg::SlopeW-1:0] in_y,
   output logic out_valid,
   output logic signed [cbz_pkg::HeadW-1:0] out_heading
);
   localparam int Steps = (CORDIC_STEPS > cbz_pkg::TableLen) ? cbz_pkg::TableLen
                                                             : CORDIC_STEPS;
   localparam int W = cbz_pkg::CordW;
   localparam int AW = cbz_pkg::AngW;
   localparam int HeadW_l = cbz_pkg::HeadW;

   cbz_pkg::cordic_type pre_in, pre_ff;
   logic pre_vld_ff;
   cbz_pkg::cordic_type stg_ff [Steps];
   logic stg_vld_ff [Steps];
   logic signed [AW-1:0] zr;
   logic signed [HeadW_l-1:0] hd_in;
   logic signed [HeadW_l-1:0] hd_ff;
   logic hd_vld_ff;

   always_comb begin
      logic signed [W-1:0] x, y;
      x = W'(in_x);
      y = W'(in_y);
      pre_in.zero = (in_x == '0) && (in_y == '0);
      pre_in.x = x;
      pre_in.y = y;
      pre_in.z = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            pre_in.x = y;
            pre_in.y = -x;
            pre_in.z = AW'(90 * 32768);
         end else begin
            pre_in.x = -y;
            pre_in.y = x;
            pre_in.z = -AW'(90 * 32768);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else begin
         pre_vld_ff <= in_valid;
      end
      pre_ff <= pre_in;
   end

   for (genvar i = 0; i < Steps; i++) begin : g_stage
      cbz_pkg::cordic_type src, nxt;
      logic src_vld;
      if (i == 0) begin : g_first
         assign src = pre_ff;
         assign src_vld = pre_vld_ff;
      end else begin : g_rest
         assign src = stg_ff[i-1];
         assign src_vld = stg_vld_ff[i-1];
      end
      always_comb begin
         nxt = src;
         if (src.y >= 0) begin
            nxt.x = src.x + (src.y >>> i);
            nxt.y = src.y - (src.x >>> i);
            nxt.z = src.z + cbz_pkg::atan_entry(i);
         end else begin
            nxt.x = src.x - (src.y >>> i);
            nxt.y = src.y + (src.x >>> i);
            nxt.z = src.z - cbz_pkg::atan_entry(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_vld_ff[i] <= 1'b0;
         end else begin
            stg_vld_ff[i] <= src_vld;
         end
         stg_ff[i] <= nxt;
      end
   end

   always_comb begin
      zr = (stg_ff[Steps-1].z + AW'(128)) >>> 8;
      if (stg_ff[Steps-1].zero) begin
         hd_in = '0;
      end else if (zr > AW'(23040)) begin
         hd_in = HeadW_l'(23040);
      end else if (zr < -AW'(23040)) begin
         hd_in = -HeadW_l'(23040);
      end else begin
         hd_in = HeadW_l'(zr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_vld_ff <= 1'b0;
      end else begin
         hd_vld_ff <= stg_vld_ff[Steps-1];
      end
      hd_ff <= hd_in;
   end

   assign out_valid = hd_vld_ff;
   assign out_heading = hd_ff;
endmodule
`default_nettype wire
